// ===== src/slab_point_locate_count_core_assert.svh =====
// assertion helpers, all clocked on clk and held off while arst_n is low
`ifndef SLAB_POINT_LOCATE_COUNT_CORE_ASSERT_SVH
`define SLAB_POINT_LOCATE_COUNT_CORE_ASSERT_SVH

// condition holds at every edge
`define SLPC_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// same-cycle implication
`define SLPC_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SLPC_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/slpc_pkg.sv =====
package slpc_pkg;

	localparam int unsigned MAX_LINES_DEF  = 1024;
	localparam int unsigned COUNT_BITS_DEF = 16;

	localparam int COORD_W   = 24;
	localparam int DIFF_W    = COORD_W + 1;
	localparam int PROD_W    = 2 * DIFF_W;
	localparam int BIN_W     = 10;
	localparam int CNT_OUT_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam int LINE_W    = 2 * COORD_W;

	typedef enum logic [1:0] {
		REQ_LOAD   = 2'd0,
		REQ_LOCATE = 2'd1,
		REQ_READ   = 2'd2,
		REQ_CLEAR  = 2'd3
	} slpc_req_t;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_RANGE = 2'd2
	} slpc_status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BOX_LEFT  = 2'd0,
		CFG_BOX_RIGHT = 2'd1,
		CFG_Y_TOP     = 2'd2,
		CFG_Y_BOTTOM  = 2'd3
	} slpc_cfg_idx_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PROBE_ADDR,
		ST_PROBE_MUL1,
		ST_PROBE_MUL2,
		ST_PROBE_CMP,
		ST_CNT_READ,
		ST_CNT_UPD,
		ST_EMIT
	} slpc_state_t;

	typedef struct packed {
		logic [1:0]                req_type;
		logic signed [COORD_W-1:0] upper_x;
		logic signed [COORD_W-1:0] lower_x;
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic [BIN_W-1:0]          bin_select;
	} slpc_in_t;

	typedef struct packed {
		logic [BIN_W-1:0]     bin;
		logic [CNT_OUT_W-1:0] bin_count;
		logic [1:0]           status;
	} slpc_out_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] top_x;
		logic signed [COORD_W-1:0] bottom_x;
	} slpc_line_t;

	// control of the shared multiplier
	typedef struct packed {
		logic mul;     // capture a*b into the product register
		logic second;  // move the previous product aside for the final compare
	} slpc_mul_cmd_t;

endpackage

// ===== src/slpc_ram.sv =====
module slpc_ram #(
	parameter int unsigned DEPTH = slpc_pkg::MAX_LINES_DEF,
	parameter int unsigned WIDTH = slpc_pkg::COUNT_BITS_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== src/slpc_cross.sv =====
module slpc_cross (
	input  logic                                   clk,
	input  slpc_pkg::slpc_mul_cmd_t                cmd,
	input  logic signed [slpc_pkg::DIFF_W-1:0]     a,
	input  logic signed [slpc_pkg::DIFF_W-1:0]     b,
	output logic                                   left
);

	import slpc_pkg::*;

	logic signed [PROD_W-1:0] prod_q;
	logic signed [PROD_W-1:0] first_q;
	logic [PROD_W:0]          diff;

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_q <= a * b;
		end
		if (cmd.second) begin
			first_q <= prod_q;
		end
	end

	// first product minus second, strictly positive
	assign diff = {first_q[PROD_W-1], first_q} - {prod_q[PROD_W-1], prod_q};
	assign left = !diff[PROD_W] && (diff != '0);

endmodule

// ===== src/slab_point_locate_count_core.sv =====
// locate: accept, per search probe ST_PROBE_ADDR, _MUL1, _MUL2, _CMP, then ST_CNT_READ,
//   ST_CNT_UPD, ST_EMIT for the bin counter and the result beat; read: from ST_CNT_READ
// load and out-of-range read: straight to ST_EMIT; clear all: ST_CLEAR sweep, ST_EMIT
// one item at a time; the probe loop through the shared multiplier sets the locate rate
// reset: config and partition count cleared, then the ST_CLEAR sweep zeroes the
//   counters while in_stall stays high (config writes still taken)
`include "slab_point_locate_count_core_assert.svh"

module slab_point_locate_count_core #(
	parameter int unsigned MAX_LINES  = slpc_pkg::MAX_LINES_DEF,
	parameter int unsigned COUNT_BITS = slpc_pkg::COUNT_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// request channel
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  slpc_pkg::slpc_in_t                   in_data,
	// result channel
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output slpc_pkg::slpc_out_t                  out_data,
	// config write channel
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [slpc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [slpc_pkg::COORD_W-1:0]         cfg_data
);

	import slpc_pkg::*;

	// line index width, partition count width, common compare widths
	localparam int AW = $clog2(MAX_LINES);
	localparam int NW = $clog2(MAX_LINES + 1);
	localparam int CW = (NW > BIN_W) ? NW : BIN_W;
	localparam int KW = (COUNT_BITS > CNT_OUT_W) ? COUNT_BITS : CNT_OUT_W;

	// config registers
	logic signed [COORD_W-1:0] box_left_q, box_right_q, y_top_q, y_bottom_q;

	// sequencer
	slpc_state_t state_q, state_d;
	logic [AW-1:0] clr_idx_q;
	logic          clr_reply_q;
	logic          clr_last;

	// partition table bookkeeping
	logic [NW-1:0] total_q;
	logic [NW-1:0] n_lines;
	logic          table_full;

	// request held while it works
	slpc_req_t req_q;
	slpc_req_t req_in;
	logic [AW-1:0] sel_q;
	logic [CW-1:0] sel_ext;
	logic          sel_ok;

	// search window and probe operands
	logic [AW-1:0] lo_q, hi_q, mid_q;
	logic [AW:0]   mid_sum;
	logic [AW-1:0] mid;
	logic [AW-1:0] lo_nx, hi_nx;
	logic          mid_zero_q;
	logic          top_lt_q;
	logic          top_lt;
	logic signed [COORD_W-1:0] px_q;
	logic signed [COORD_W-1:0] ay;
	logic signed [DIFF_W-1:0]  dpy_q, dey_q, pxa_q;
	logic signed [COORD_W-1:0] tx, bx, ax, ex;
	logic signed [DIFF_W-1:0]  dex, pxa;

	// line memory
	logic             line_we, line_re;
	slpc_line_t       line_wr, line_rd;
	logic [LINE_W-1:0] line_rdata;
	logic [AW-1:0]    line_raddr;

	// counter memory
	logic                  cnt_we, cnt_re;
	logic [AW-1:0]         cnt_waddr, cnt_raddr;
	logic [COUNT_BITS-1:0] cnt_wdata, cnt_rdata, cnt_inc;
	logic                  cnt_sat;
	logic [KW-1:0]         cnt_ext;

	// shared multiplier
	slpc_mul_cmd_t            mul_cmd;
	logic signed [DIFF_W-1:0] mul_a, mul_b;
	logic                     left;

	// pending result and output register
	logic [BIN_W-1:0]     res_bin_q;
	logic [CNT_OUT_W-1:0] res_cnt_q;
	slpc_status_t         res_status_q;
	logic                 out_valid_q;
	slpc_out_t            out_q;
	logic                 emit;
	logic                 accept;
	logic [CW-1:0]        load_bin_ext, hi_ext;

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// config writes land whenever they come; the host keeps them to idle periods
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_left_q  <= '0;
			box_right_q <= '0;
			y_top_q     <= '0;
			y_bottom_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (slpc_cfg_idx_t'(cfg_index))
				CFG_BOX_LEFT:  box_left_q  <= cfg_data;
				CFG_BOX_RIGHT: box_right_q <= cfg_data;
				CFG_Y_TOP:     y_top_q     <= cfg_data;
				CFG_Y_BOTTOM:  y_bottom_q  <= cfg_data;
			endcase
		end
	end

	// lines are left wall, partitions, right wall
	assign n_lines    = total_q + NW'(2);
	assign table_full = (total_q >= NW'(MAX_LINES - 2));
	assign req_in     = slpc_req_t'(in_data.req_type);
	assign accept     = in_valid && !in_stall;

	// read requests: a bin index must fall below the line count
	assign sel_ext = CW'(in_data.bin_select);
	assign sel_ok  = (sel_ext < CW'(n_lines));

	assign clr_last = (clr_idx_q == AW'(MAX_LINES - 1));

	// per-query geometry: the line runs from its lower-y end, ay is that end's y
	assign top_lt = (y_top_q < y_bottom_q);
	assign ay     = top_lt ? y_top_q : y_bottom_q;

	// midpoint of the current window
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid     = mid_sum[AW:1];
	assign line_raddr = (mid == '0) ? '0 : mid - AW'(1);

	// probed line ends; the left wall sits at index zero, the right wall is never probed
	assign line_rd = line_rdata;
	assign tx  = mid_zero_q ? box_left_q : line_rd.top_x;
	assign bx  = mid_zero_q ? box_left_q : line_rd.bottom_x;
	assign ax  = top_lt_q ? tx : bx;
	assign ex  = top_lt_q ? bx : tx;
	assign dex = ex - ax;
	assign pxa = px_q - ax;

	// window update after the side test
	assign lo_nx = left ? lo_q : mid_q + AW'(1);
	assign hi_nx = left ? mid_q : hi_q;

	assign line_wr.top_x    = in_data.upper_x;
	assign line_wr.bottom_x = in_data.lower_x;

	// saturating counter bump
	assign cnt_sat = &cnt_rdata;
	assign cnt_inc = cnt_sat ? cnt_rdata : cnt_rdata + COUNT_BITS'(1);
	assign cnt_ext = (req_q == REQ_LOCATE) ? KW'(cnt_inc) : KW'(cnt_rdata);

	assign load_bin_ext = CW'(total_q + NW'(1));
	assign hi_ext       = CW'(hi_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		line_we   = 1'b0;
		line_re   = 1'b0;
		cnt_we    = 1'b0;
		cnt_re    = 1'b0;
		cnt_waddr = hi_q;
		cnt_wdata = cnt_inc;
		cnt_raddr = hi_q;
		mul_cmd   = '0;
		mul_a     = '0;
		mul_b     = '0;
		emit      = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				// zero one counter per cycle
				cnt_we    = 1'b1;
				cnt_waddr = clr_idx_q;
				cnt_wdata = '0;
				if (clr_last) begin
					state_d = clr_reply_q ? ST_EMIT : ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					unique case (req_in)
						REQ_LOAD: begin
							line_we = !table_full;
							state_d = ST_EMIT;
						end
						REQ_LOCATE: state_d = ST_PROBE_ADDR;
						REQ_READ:   state_d = sel_ok ? ST_CNT_READ : ST_EMIT;
						REQ_CLEAR:  state_d = ST_CLEAR;
					endcase
				end
			end
			ST_PROBE_ADDR: begin
				line_re = 1'b1;
				state_d = ST_PROBE_MUL1;
			end
			ST_PROBE_MUL1: begin
				// (ex - ax) * (py - ay)
				mul_cmd.mul = 1'b1;
				mul_a       = dex;
				mul_b       = dpy_q;
				state_d     = ST_PROBE_MUL2;
			end
			ST_PROBE_MUL2: begin
				// (px - ax) * (ey - ay)
				mul_cmd.mul    = 1'b1;
				mul_cmd.second = 1'b1;
				mul_a          = pxa_q;
				mul_b          = dey_q;
				state_d        = ST_PROBE_CMP;
			end
			ST_PROBE_CMP: begin
				state_d = (lo_nx == hi_nx) ? ST_CNT_READ : ST_PROBE_ADDR;
			end
			ST_CNT_READ: begin
				cnt_re    = 1'b1;
				cnt_raddr = (req_q == REQ_LOCATE) ? hi_q : sel_q;
				state_d   = ST_CNT_UPD;
			end
			ST_CNT_UPD: begin
				cnt_we  = (req_q == REQ_LOCATE) && !cnt_sat;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				emit = !out_valid_q || !out_stall;
				if (emit) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= '0;
			clr_idx_q   <= '0;
			clr_reply_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept && req_in == REQ_LOAD && !table_full) begin
				total_q <= total_q + NW'(1);
			end else if (accept && req_in == REQ_CLEAR) begin
				total_q <= '0;
			end

			if (accept && req_in == REQ_CLEAR) begin
				clr_reply_q <= 1'b1;
			end else if (state_q == ST_CLEAR && clr_last) begin
				clr_reply_q <= 1'b0;
			end

			if (state_q == ST_CLEAR) begin
				clr_idx_q <= clr_last ? '0 : clr_idx_q + AW'(1);
			end

			// output slot: a beat leaves, a new one may land in the same cycle
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q        <= req_in;
			sel_q        <= sel_ext[AW-1:0];
			px_q         <= in_data.point_x;
			top_lt_q     <= top_lt;
			dpy_q        <= in_data.point_y - ay;
			dey_q        <= top_lt ? y_bottom_q - y_top_q : y_top_q - y_bottom_q;
			lo_q         <= '0;
			hi_q         <= AW'(total_q + NW'(1));
			res_cnt_q    <= '0;
			res_status_q <= STATUS_OK;
			res_bin_q    <= '0;
			unique case (req_in)
				REQ_LOAD: begin
					if (table_full) begin
						res_status_q <= STATUS_FULL;
					end else begin
						res_bin_q <= load_bin_ext[BIN_W-1:0];
					end
				end
				REQ_READ: begin
					res_bin_q <= in_data.bin_select;
					if (!sel_ok) begin
						res_status_q <= STATUS_RANGE;
					end
				end
				REQ_LOCATE, REQ_CLEAR: begin
				end
			endcase
		end

		if (state_q == ST_PROBE_ADDR) begin
			mid_q      <= mid;
			mid_zero_q <= (mid == '0);
		end
		if (state_q == ST_PROBE_MUL1) begin
			pxa_q <= pxa;
		end
		if (state_q == ST_PROBE_CMP) begin
			lo_q <= lo_nx;
			hi_q <= hi_nx;
		end

		if (state_q == ST_CNT_UPD) begin
			res_cnt_q <= cnt_ext[CNT_OUT_W-1:0];
			if (req_q == REQ_LOCATE) begin
				res_bin_q <= hi_ext[BIN_W-1:0];
			end
		end

		if (emit) begin
			out_q.bin       <= res_bin_q;
			out_q.bin_count <= res_cnt_q;
			out_q.status    <= res_status_q;
		end
	end

	slpc_ram #(
		.DEPTH (MAX_LINES),
		.WIDTH (LINE_W)
	) u_line_mem (
		.clk   (clk),
		.we    (line_we),
		.waddr (total_q[AW-1:0]),
		.wdata (line_wr),
		.re    (line_re),
		.raddr (line_raddr),
		.rdata (line_rdata)
	);

	slpc_ram #(
		.DEPTH (MAX_LINES),
		.WIDTH (COUNT_BITS)
	) u_cnt_mem (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.re    (cnt_re),
		.raddr (cnt_raddr),
		.rdata (cnt_rdata)
	);

	slpc_cross u_cross (
		.clk  (clk),
		.cmd  (mul_cmd),
		.a    (mul_a),
		.b    (mul_b),
		.left (left)
	);

	`SLPC_ALWAYS(a_total_bound, total_q <= NW'(MAX_LINES - 2), "partition count past table size")
	`SLPC_IMPLY(a_probe_order, state_q == ST_PROBE_ADDR, lo_q < hi_q, "probe with empty window")
	`SLPC_IMPLY(a_probe_span, state_q == ST_PROBE_ADDR, NW'(hi_q) <= total_q + NW'(1), "window past last line")
	`SLPC_NEXT(a_emit_lands, emit, out_valid_q && state_q == ST_IDLE, "result beat not posted")

endmodule

// ===== tb/tb_slab_point_locate_count_core.sv =====
module tb_slab_point_locate_count_core;
	import slpc_pkg::*;

	// counters saturate here
	localparam longint COUNT_CAP   = (longint'(1) << COUNT_BITS_DEF) - 1;
	// watchdog limit on the whole run, set well above the slowest correct run
	localparam longint CYCLE_LIMIT = 5000000;
	localparam longint COORD_MIN   = -(longint'(1) << (COORD_W - 1));
	localparam longint COORD_MAX   = (longint'(1) << (COORD_W - 1)) - 1;

	// own copy of walls, partitions and bin counters; predicts one result beat per request
	class slab_bin_ledger;
		logic signed [COORD_W-1:0] wall_left, wall_right, top_y, bottom_y;
		logic signed [COORD_W-1:0] part_top [MAX_LINES_DEF];
		logic signed [COORD_W-1:0] part_bottom [MAX_LINES_DEF];
		int unsigned part_count;
		int unsigned hits [MAX_LINES_DEF];
		slpc_out_t due [$];
		int unsigned mismatches;

		function new();
			wall_left = '0;
			wall_right = '0;
			top_y = '0;
			bottom_y = '0;
			part_count = 0;
			mismatches = 0;
			foreach (hits[i]) hits[i] = 0;
		endfunction

		function void set_register(slpc_cfg_idx_t idx, logic signed [COORD_W-1:0] value);
			case (idx)
				CFG_BOX_LEFT:  wall_left = value;
				CFG_BOX_RIGHT: wall_right = value;
				CFG_Y_TOP:     top_y = value;
				CFG_Y_BOTTOM:  bottom_y = value;
			endcase
		endfunction

		// exact cross product, measured from the endpoint with the smaller y
		function bit strictly_left(longint px, longint py, longint tx, longint bx);
			longint ax, ay, ex, ey;
			if (top_y < bottom_y) begin
				ax = tx; ay = top_y; ex = bx; ey = bottom_y;
			end else begin
				ax = bx; ay = bottom_y; ex = tx; ey = top_y;
			end
			return (ex - ax) * (py - ay) - (px - ax) * (ey - ay) > 0;
		endfunction

		// line 0 is the left wall, the last one the right wall
		function void line_x(int unsigned idx, int unsigned lines,
				output longint tx, output longint bx);
			if (idx == 0) begin
				tx = wall_left; bx = wall_left;
			end else if (idx >= lines - 1) begin
				tx = wall_right; bx = wall_right;
			end else begin
				tx = part_top[idx-1]; bx = part_bottom[idx-1];
			end
		endfunction

		function void note_request(slpc_in_t req);
			slpc_out_t res;
			int unsigned lines, lo, hi, mid;
			longint tx, bx;
			res = '0;
			res.status = STATUS_OK;
			lines = part_count + 2;
			case (req.req_type)
				REQ_LOAD: begin
					if (part_count >= MAX_LINES_DEF - 2)
						res.status = STATUS_FULL;
					else begin
						part_top[part_count] = req.upper_x;
						part_bottom[part_count] = req.lower_x;
						part_count++;
						res.bin = BIN_W'(part_count);
					end
				end
				REQ_LOCATE: begin
					lo = 0;
					hi = lines - 1;
					while (lo < hi) begin
						mid = (lo + hi) >> 1;
						line_x(mid, lines, tx, bx);
						if (strictly_left($signed(req.point_x), $signed(req.point_y), tx, bx))
							hi = mid;
						else
							lo = mid + 1;
					end
					if (hits[hi] < COUNT_CAP) hits[hi]++;
					res.bin = BIN_W'(hi);
					res.bin_count = CNT_OUT_W'(hits[hi]);
				end
				REQ_READ: begin
					res.bin = req.bin_select;
					if (req.bin_select >= lines)
						res.status = STATUS_RANGE;
					else
						res.bin_count = CNT_OUT_W'(hits[req.bin_select]);
				end
				default: begin
					foreach (hits[i]) hits[i] = 0;
					part_count = 0;
				end
			endcase
			due = {due, res};
		endfunction

		function void flag(string msg);
			mismatches++;
			if (mismatches <= 10) $display("mismatch: %s", msg);
		endfunction

		function void check_result(slpc_out_t got);
			slpc_out_t want;
			if (due.size() == 0) begin
				flag($sformatf("result beat with nothing due: bin %0d count %0d status %0d",
					got.bin, got.bin_count, got.status));
				return;
			end
			want = due.pop_front();
			if (got.bin !== want.bin)
				flag($sformatf("bin expected %0d got %0d", want.bin, got.bin));
			if (got.bin_count !== want.bin_count)
				flag($sformatf("bin_count of bin %0d expected %0d got %0d",
					want.bin, want.bin_count, got.bin_count));
			if (got.status !== want.status)
				flag($sformatf("status of bin %0d expected %0d got %0d",
					want.bin, want.status, got.status));
		endfunction
	endclass

	// dut signals, all inputs known from time zero
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	slpc_in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	slpc_out_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [COORD_W-1:0] cfg_data = '0;

	slab_bin_ledger ledger;

	// idle rates in percent per cycle, and the receiver's long hold-off
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_left = 0;
	int unsigned sent_items = 0;
	longint cycles = 0;

	// current box, and the partitions of the running sequence for aiming points
	longint geo_left, geo_right, geo_top, geo_bottom;
	longint part_tops [$];
	longint part_bots [$];

	slab_point_locate_count_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	// receiver: long hold-off when asked, random stall otherwise
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_stall <= 1'b1;
		end else
			out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// every accepted result beat goes against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) ledger.check_result(out_data);
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("** slab_point_locate_count_core: FAILED **");
			$finish;
		end
	end

	function automatic logic signed [COORD_W-1:0] clamp24(longint v);
		if (v < COORD_MIN) v = COORD_MIN;
		else if (v > COORD_MAX) v = COORD_MAX;
		return COORD_W'(v);
	endfunction

	function automatic longint pick(longint lo, longint hi);
		return lo + longint'($urandom_range(32'(hi - lo), 0));
	endfunction

	// unused fields carry junk so every bit toggles
	function automatic slpc_in_t scrambled(slpc_req_t kind);
		slpc_in_t r;
		r.req_type = kind;
		r.upper_x = COORD_W'($urandom);
		r.lower_x = COORD_W'($urandom);
		r.point_x = COORD_W'($urandom);
		r.point_y = COORD_W'($urandom);
		r.bin_select = BIN_W'($urandom);
		return r;
	endfunction

	// one request beat; valid stays up after acceptance until the next call or a drain
	task automatic push_request(slpc_in_t r);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= r;
		do @(posedge clk); while (in_stall);
		ledger.note_request(r);
		sent_items++;
	endtask

	task automatic load_partition(longint upper, longint lower);
		slpc_in_t r;
		r = scrambled(REQ_LOAD);
		r.upper_x = clamp24(upper);
		r.lower_x = clamp24(lower);
		push_request(r);
	endtask

	task automatic locate_point(longint px, longint py);
		slpc_in_t r;
		r = scrambled(REQ_LOCATE);
		r.point_x = clamp24(px);
		r.point_y = clamp24(py);
		push_request(r);
	endtask

	task automatic read_bin(int unsigned sel);
		slpc_in_t r;
		r = scrambled(REQ_READ);
		r.bin_select = BIN_W'(sel);
		push_request(r);
	endtask

	task automatic clear_all();
		push_request(scrambled(REQ_CLEAR));
	endtask

	// drop valid, then wait for every predicted beat
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (ledger.due.size() != 0) @(posedge clk);
	endtask

	task automatic write_register(slpc_cfg_idx_t idx, longint v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= COORD_W'(v);
		do @(posedge clk); while (!cfg_ready);
		ledger.set_register(idx, COORD_W'(v));
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// new box geometry, only once every predicted beat has come back
	task automatic set_box(longint l, longint r, longint t, longint b);
		wait_drained();
		repeat (4) @(posedge clk);
		write_register(CFG_BOX_LEFT, l);
		write_register(CFG_BOX_RIGHT, r);
		write_register(CFG_Y_TOP, t);
		write_register(CFG_Y_BOTTOM, b);
		geo_left = l;
		geo_right = r;
		geo_top = t;
		geo_bottom = b;
	endtask

	// k non-crossing partitions, tops and bottoms both ascending across the box
	task automatic load_ascending(int k);
		longint span, mid_x, jit, t, b;
		part_tops.delete();
		part_bots.delete();
		span = geo_right - geo_left;
		jit = span / (4 * (k + 1));
		for (int i = 0; i < k; i++) begin
			mid_x = geo_left + span * (i + 1) / (k + 1);
			t = mid_x + pick(-jit, jit);
			b = mid_x + pick(-jit, jit);
			part_tops = {part_tops, t};
			part_bots = {part_bots, b};
			load_partition(t, b);
		end
	endtask

	// mostly inside the slab, some exactly on a line, some anywhere
	task automatic locate_somewhere();
		longint span, ylo, yhi, px, py;
		int unsigned mode, i;
		span = geo_right - geo_left;
		ylo = (geo_top < geo_bottom) ? geo_top : geo_bottom;
		yhi = (geo_top < geo_bottom) ? geo_bottom : geo_top;
		mode = $urandom_range(99);
		if (mode < 10 && part_tops.size() != 0) begin
			// endpoint of a partition, cross product exactly zero
			i = $urandom_range(part_tops.size() - 1);
			if ($urandom_range(1)) begin
				px = part_tops[i]; py = geo_top;
			end else begin
				px = part_bots[i]; py = geo_bottom;
			end
		end else if (mode < 16) begin
			px = $urandom_range(1) ? geo_left : geo_right;
			py = pick(ylo, yhi);
		end else if (mode < 24) begin
			px = pick(COORD_MIN, COORD_MAX);
			py = pick(COORD_MIN, COORD_MAX);
		end else begin
			px = pick(geo_left - span / 8, geo_right + span / 8);
			py = (yhi > ylo) ? pick(ylo, yhi) : pick(ylo - 64, ylo + 64);
		end
		locate_point(px, py);
	endtask

	// well-formed sequences (clear, ascending loads, locates and reads) plus noise bursts
	task automatic run_phase(int unsigned count);
		int unsigned stop;
		int k;
		stop = sent_items + count;
		while (sent_items < stop) begin
			if ($urandom_range(99) < 80) begin
				clear_all();
				k = ($urandom_range(9) == 0) ? $urandom_range(60, 13) : $urandom_range(12, 0);
				load_ascending(k);
				repeat ($urandom_range(30, 5)) begin
					if ($urandom_range(99) < 85)
						locate_somewhere();
					else if ($urandom_range(3) != 0)
						read_bin($urandom_range(k + 2, 0));
					else
						read_bin($urandom_range(1023));
				end
			end else begin
				repeat ($urandom_range(6, 1))
					push_request(scrambled(slpc_req_t'($urandom_range(3))));
			end
		end
	endtask

	initial begin
		ledger = new();
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		// config goes in while the counter sweep after reset is still running
		send_idle_pct = 8;
		recv_idle_pct = 56;
		set_box(-1000, 1000, 500, -500);

		// directed: reads at the range edge on an empty table
		read_bin(0);
		read_bin(1);
		read_bin(2);
		read_bin(1023);
		// walls only: left of left wall, on each wall, far outside
		locate_point(-2000, 0);
		locate_point(-1000, 0);
		locate_point(1000, 0);
		locate_point(5000, 9999);
		// three partitions, the middle one vertical
		load_partition(-500, -300);
		load_partition(0, 0);
		load_partition(400, 600);
		locate_point(0, 123);
		locate_point(400, 500);
		locate_point(-700, -600);
		read_bin(3);
		read_bin(4);
		read_bin(5);
		clear_all();
		read_bin(1);
		// coordinate extremes
		load_partition(COORD_MIN, COORD_MAX);
		load_partition(COORD_MAX, COORD_MIN);
		locate_point(COORD_MAX, COORD_MIN);
		locate_point(COORD_MIN, COORD_MAX);
		read_bin(1023);
		clear_all();

		// sender rarely idle, receiver often stalled; long hold-off midway fills the block
		run_phase(90);
		hold_left = 400;
		run_phase(90);

		// extreme box with y reversed, roles of the idling swapped, one full pause midway
		set_box(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX);
		send_idle_pct = 56;
		recv_idle_pct = 8;
		run_phase(90);
		wait_drained();
		run_phase(90);

		// flat slab with top equal to bottom, no idling
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_box(-70000, 90000, 1234, 1234);
		run_phase(90);

		// fill the partition table, then loads past full, locates over all lines
		set_box(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
		clear_all();
		load_ascending(MAX_LINES_DEF - 2);
		repeat (3) load_partition(pick(COORD_MIN, COORD_MAX), pick(COORD_MIN, COORD_MAX));
		repeat (60) locate_somewhere();
		read_bin(0);
		read_bin(1);
		read_bin(1022);
		read_bin(1023);
		repeat (10) read_bin($urandom_range(1023));
		clear_all();
		read_bin(2);

		// repeated hits on bin 0 of a narrow box, then one on bin 1
		set_box(0, 100, 100, -100);
		clear_all();
		repeat (20) locate_point(pick(-1000, -1), pick(-100, 100));
		read_bin(0);
		locate_point(50, 0);
		read_bin(1);

		// tail: everything back, then a clear's worth of quiet
		wait_drained();
		repeat (1100) @(posedge clk);
		if (ledger.mismatches == 0 && ledger.due.size() == 0)
			$display("** slab_point_locate_count_core: PASSED **");
		else
			$display("** slab_point_locate_count_core: FAILED **");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+src
src/slpc_pkg.sv
src/slpc_ram.sv
src/slpc_cross.sv
src/slab_point_locate_count_core.sv
tb/tb_slab_point_locate_count_core.sv
